FILE: rtl/hnm_pkg.sv
// Shared widths, constants and helper functions for the height-map normal encoder.
// No dependencies; imported by hnm_div and heightmap_normal_encoder.
package hnm_pkg;

  localparam int HGT_W   = 8;
  localparam int SCALE_W = 16;
  localparam int MAG_W   = 24;
  localparam int FQ_W    = 17;
  localparam int SUM_W   = 20;
  localparam int SMAG_W  = 19;
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = RAD_W / 2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
  localparam logic [16:0]        ONE_Q16     = 17'd65536;

  function automatic int max_of(input int x, input int y);
    return (x > y) ? x : y;
  endfunction

  // Clamp a sign-magnitude Q1.16 component to [-1, 1] and map it to a byte; zero maps to 0 (y to +1).
  function automatic logic [7:0] to_byte(input logic neg, input logic [FQ_W-1:0] q,
                                         input logic zero, input logic is_y);
    logic [16:0] m;
    logic [17:0] u;
    logic [25:0] p;
    m = (q > ONE_Q16) ? ONE_Q16 : q;
    u = neg ? (18'(ONE_Q16) - 18'(m)) : (18'(ONE_Q16) + 18'(m));
    if (zero) begin
      u = is_y ? (18'(ONE_Q16) << 1) : 18'(ONE_Q16);
    end
    p = (26'(u) << 8) - 26'(u);
    return p[24:17];
  endfunction

endpackage

FILE: rtl/hnm_sqrt.sv
// Pipelined integer square root, one result bit per stage, several lanes in lockstep.
// Standalone; instantiated by heightmap_normal_encoder.
module hnm_sqrt #(
  parameter int W     = 64,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [LANES-1:0][W-1:0]       in_rad,
  input  logic [SW-1:0]                 in_side,
  output logic                          out_valid,
  output logic [LANES-1:0][W/2-1:0]     out_root,
  output logic [SW-1:0]                 out_side
);
  localparam int N = W / 2;

  logic [LANES-1:0][W-1:0] rad  [N+1];
  logic [LANES-1:0][N+1:0] rem  [N+1];
  logic [LANES-1:0][N-1:0] root [N+1];
  logic                    vld  [N+1];
  logic [SW-1:0]           side [N+1];

  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign vld[0]  = in_valid;
  assign side[0] = in_side;

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [LANES-1:0][W-1:0] rad_next;
    logic [LANES-1:0][N+1:0] rem_next;
    logic [LANES-1:0][N-1:0] root_next;

    always_comb begin
      logic [N+1:0] rsh;
      logic [N+1:0] tr;
      for (int l = 0; l < LANES; l++) begin
        rsh = {rem[g][l][N-1:0], rad[g][l][W-1:W-2]};
        tr  = {root[g][l], 2'b01};
        rad_next[l] = rad[g][l] << 2;
        if (rsh >= tr) begin
          rem_next[l]  = rsh - tr;
          root_next[l] = {root[g][l][N-2:0], 1'b1};
        end else begin
          rem_next[l]  = rsh;
          root_next[l] = {root[g][l][N-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[g+1]  <= rad_next;
        rem[g+1]  <= rem_next;
        root[g+1] <= root_next;
        side[g+1] <= side[g];
      end
    end
  end

  assign out_valid = vld[N];
  assign out_root  = root[N];
  assign out_side  = side[N];

endmodule

FILE: rtl/hnm_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage, several lanes.
// Depends on hnm_pkg; instantiated by heightmap_normal_encoder.
module hnm_div #(
  parameter int NW    = 48,
  parameter int DW    = 32,
  parameter int QW    = 17,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [LANES-1:0][NW-1:0] in_num,
  input  logic [LANES-1:0][DW-1:0] in_den,
  input  logic [SW-1:0]            in_side,
  output logic                     out_valid,
  output logic [LANES-1:0][QW-1:0] out_quo,
  output logic [SW-1:0]            out_side
);
  import hnm_pkg::*;

  localparam int IW = max_of(NW, DW + QW);

  logic [LANES-1:0][IW-1:0] rem  [QW+1];
  logic [LANES-1:0][DW-1:0] den  [QW+1];
  logic [LANES-1:0][QW-1:0] quo  [QW+1];
  logic                     vld  [QW+1];
  logic [SW-1:0]            side [QW+1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem[0][l] = IW'(in_num[l]);
    end
  end
  assign den[0]  = in_den;
  assign quo[0]  = '0;
  assign vld[0]  = in_valid;
  assign side[0] = in_side;

  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int B = QW - 1 - g;
    logic [LANES-1:0][IW-1:0] rem_next;
    logic [LANES-1:0][QW-1:0] quo_next;

    always_comb begin
      logic [IW-1:0] sub;
      for (int l = 0; l < LANES; l++) begin
        sub         = IW'(den[g][l]) << B;
        quo_next[l] = quo[g][l];
        if (rem[g][l] >= sub) begin
          rem_next[l]    = rem[g][l] - sub;
          quo_next[l][B] = 1'b1;
        end else begin
          rem_next[l] = rem[g][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1]  <= rem_next;
        den[g+1]  <= den[g];
        quo[g+1]  <= quo_next;
        side[g+1] <= side[g];
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_quo   = quo[QW];
  assign out_side  = side[QW];

endmodule

FILE: rtl/heightmap_normal_encoder.sv
// Top level of the height-map normal encoder: scaling, face normals, sum and final normalize.
// Depends on hnm_pkg, hnm_sqrt and hnm_div.
//
//   channel | dir | handshake            | payload
//   s_*     | in  | s_tvalid / s_tready  | s_tdata: center, up, left, down, right heights
//   m_*     | out | m_tvalid / m_tready  | m_tdata: alpha, red, green, blue
//   cfg_*   | in  | cfg_valid / cfg_ready| cfg_data: height_scale (Q8.8)
//
// One texel per cycle while the output is not stalled; the pipeline is the two 32-stage
// square roots and the two 17-stage dividers plus seven arithmetic stages.
// rst is synchronous and clears all valid bits; height_scale returns to 1.0.
// A stalled output freezes the whole pipeline; s_tready follows the output register.
module heightmap_normal_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // center, up, left, down, right (8 bits each)
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // alpha_height, normal_red, normal_green, normal_blue
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import hnm_pkg::*;

  localparam int FX [4] = '{1, 1, 3, 3};
  localparam int FZ [4] = '{0, 2, 2, 0};

  logic               en;
  logic [SCALE_W-1:0] scale_q;

  assign en        = ~m_tvalid | m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_valid) begin
      scale_q <= cfg_data;
    end
  end

  // Stage 1: neighbor differences times scale, as sign and magnitude.
  logic                   v1;
  logic [3:0][MAG_W-1:0]  mag1;
  logic [3:0]             neg1;
  logic [HGT_W-1:0]       hc1;
  logic [3:0][MAG_W-1:0]  mag1_next;
  logic [3:0]             neg1_next;

  always_comb begin
    logic signed [8:0]  dif;
    logic signed [25:0] prod;
    logic        [25:0] mag;
    for (int i = 0; i < 4; i++) begin
      dif  = $signed({1'b0, s_tdata[8*(i+1) +: 8]}) - $signed({1'b0, s_tdata[7:0]});
      prod = dif * $signed({1'b0, scale_q});
      mag  = prod[25] ? 26'(-prod) : 26'(prod);
      mag1_next[i] = mag[MAG_W-1:0];
      neg1_next[i] = prod[25];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1 <= mag1_next;
      neg1 <= neg1_next;
      hc1  <= s_tdata[7:0];
    end
  end

  // Stage 2: squares.
  logic                    v2;
  logic [3:0][2*MAG_W-1:0] sq2;
  logic [3:0][MAG_W-1:0]   mag2;
  logic [3:0]              neg2;
  logic [HGT_W-1:0]        hc2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq2[i] <= mag1[i] * mag1[i];
      end
      mag2 <= mag1;
      neg2 <= neg1;
      hc2  <= hc1;
    end
  end

  // Stage 3: face length radicands.
  logic                   v3;
  logic [3:0][RAD_W-1:0]  rad3;
  logic [3:0][MAG_W-1:0]  mag3;
  logic [3:0]             neg3;
  logic [HGT_W-1:0]       hc3;
  logic [3:0][RAD_W-1:0]  rad3_next;

  always_comb begin
    logic [49:0] s;
    for (int f = 0; f < 4; f++) begin
      s = 50'(sq2[FX[f]]) + 50'(sq2[FZ[f]]) + 50'(ONE_Q16);
      rad3_next[f] = RAD_W'(s) << 14;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad3 <= rad3_next;
      mag3 <= mag2;
      neg3 <= neg2;
      hc3  <= hc2;
    end
  end

  // Face lengths.
  localparam int S1_W = HGT_W + 4 + 4 * MAG_W;

  logic                   sq1_valid;
  logic [3:0][ROOT_W-1:0] sq1_root;
  logic [S1_W-1:0]        sq1_side;

  hnm_sqrt #(.W(RAD_W), .LANES(4), .SW(S1_W)) u_face_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in_rad    (rad3),
    .in_side   ({hc3, neg3, mag3}),
    .out_valid (sq1_valid),
    .out_root  (sq1_root),
    .out_side  (sq1_side)
  );

  // Face normal components: lane f*3 + {x, y, z}.
  localparam int D1_NW = 48;

  logic [3:0][MAG_W-1:0]   mag4;
  logic [11:0][D1_NW-1:0]  d1_num;
  logic [11:0][ROOT_W-1:0] d1_den;

  assign mag4 = sq1_side[4*MAG_W-1:0];

  always_comb begin
    for (int f = 0; f < 4; f++) begin
      d1_num[3*f]     = D1_NW'(mag4[FX[f]]) << 23;
      d1_num[3*f + 1] = D1_NW'(1) << 31;
      d1_num[3*f + 2] = D1_NW'(mag4[FZ[f]]) << 23;
      d1_den[3*f]     = sq1_root[f];
      d1_den[3*f + 1] = sq1_root[f];
      d1_den[3*f + 2] = sq1_root[f];
    end
  end

  logic                  d1_valid;
  logic [11:0][FQ_W-1:0] d1_quo;
  logic [11:0]           d1_side;

  hnm_div #(.NW(D1_NW), .DW(ROOT_W), .QW(FQ_W), .LANES(12), .SW(HGT_W + 4)) u_face_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq1_valid),
    .in_num    (d1_num),
    .in_den    (d1_den),
    .in_side   (sq1_side[S1_W-1 -: HGT_W + 4]),
    .out_valid (d1_valid),
    .out_quo   (d1_quo),
    .out_side  (d1_side)
  );

  // Stage 4: sum of the four face normals.
  logic                     v4;
  logic signed [SUM_W-1:0]  sx4, sy4, sz4;
  logic [HGT_W-1:0]         hc4;
  logic signed [SUM_W-1:0]  sx4_next, sy4_next, sz4_next;

  always_comb begin
    logic [3:0]              nd;
    logic                    xn;
    logic                    zn;
    logic signed [SUM_W-1:0] qx, qy, qz;
    nd = d1_side[3:0];
    sx4_next = '0;
    sy4_next = '0;
    sz4_next = '0;
    for (int f = 0; f < 4; f++) begin
      xn = (f < 2) ? nd[1] : ~nd[3];
      zn = (f == 0 || f == 3) ? nd[0] : ~nd[2];
      qx = $signed(SUM_W'(d1_quo[3*f]));
      qy = $signed(SUM_W'(d1_quo[3*f + 1]));
      qz = $signed(SUM_W'(d1_quo[3*f + 2]));
      sx4_next = xn ? (sx4_next - qx) : (sx4_next + qx);
      sy4_next = sy4_next + qy;
      sz4_next = zn ? (sz4_next - qz) : (sz4_next + qz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx4 <= sx4_next;
      sy4 <= sy4_next;
      sz4 <= sz4_next;
      hc4 <= d1_side[11:4];
    end
  end

  // Stage 5: squares and magnitudes of the sum.
  logic                    v5;
  logic [2:0][37:0]        sq5;
  logic [2:0][SMAG_W-1:0]  mag5;
  logic [2:0]              neg5;
  logic [HGT_W-1:0]        hc5;
  logic signed [2*SUM_W-1:0] px, py, pz;
  logic [SUM_W-1:0]        ax, ay, az;

  assign px = sx4 * sx4;
  assign py = sy4 * sy4;
  assign pz = sz4 * sz4;
  assign ax = sx4[SUM_W-1] ? SUM_W'(-sx4) : SUM_W'(sx4);
  assign ay = sy4[SUM_W-1] ? SUM_W'(-sy4) : SUM_W'(sy4);
  assign az = sz4[SUM_W-1] ? SUM_W'(-sz4) : SUM_W'(sz4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq5[0]  <= px[37:0];
      sq5[1]  <= py[37:0];
      sq5[2]  <= pz[37:0];
      mag5[0] <= ax[SMAG_W-1:0];
      mag5[1] <= ay[SMAG_W-1:0];
      mag5[2] <= az[SMAG_W-1:0];
      neg5    <= {sz4[SUM_W-1], sy4[SUM_W-1], sx4[SUM_W-1]};
      hc5     <= hc4;
    end
  end

  // Stage 6: length radicand of the sum.
  logic                    v6;
  logic [0:0][RAD_W-1:0]   rad6;
  logic [2:0][SMAG_W-1:0]  mag6;
  logic [2:0]              neg6;
  logic [HGT_W-1:0]        hc6;
  logic [38:0]             tsum;

  assign tsum = 39'(sq5[0]) + 39'(sq5[1]) + 39'(sq5[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad6[0] <= RAD_W'(tsum) << 24;
      mag6    <= mag5;
      neg6    <= neg5;
      hc6     <= hc5;
    end
  end

  localparam int S2_W = HGT_W + 3 + 3 * SMAG_W;

  logic                   sq2_valid;
  logic [0:0][ROOT_W-1:0] sq2_root;
  logic [S2_W-1:0]        sq2_side;

  hnm_sqrt #(.W(RAD_W), .LANES(1), .SW(S2_W)) u_sum_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v6),
    .in_rad    (rad6),
    .in_side   ({hc6, neg6, mag6}),
    .out_valid (sq2_valid),
    .out_root  (sq2_root),
    .out_side  (sq2_side)
  );

  // Final normalize.
  localparam int D2_NW = SMAG_W + 28;

  logic [2:0][SMAG_W-1:0]  mag7;
  logic [2:0][D2_NW-1:0]   d2_num;
  logic [2:0][ROOT_W-1:0]  d2_den;
  logic                    zero7;

  assign mag7  = sq2_side[3*SMAG_W-1:0];
  assign zero7 = (sq2_root[0] == '0);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      d2_num[c] = D2_NW'(mag7[c]) << 28;
      d2_den[c] = sq2_root[0];
    end
  end

  logic                 d2_valid;
  logic [2:0][FQ_W-1:0] d2_quo;
  logic [HGT_W+3:0]     d2_side;

  hnm_div #(.NW(D2_NW), .DW(ROOT_W), .QW(FQ_W), .LANES(3), .SW(HGT_W + 4)) u_sum_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq2_valid),
    .in_num    (d2_num),
    .in_den    (d2_den),
    .in_side   ({sq2_side[S2_W-1 -: HGT_W + 3], zero7}),
    .out_valid (d2_valid),
    .out_quo   (d2_quo),
    .out_side  (d2_side)
  );

  // Stage 7: byte mapping into the output register.
  logic [2:0] neg8;
  logic       zero8;

  assign neg8  = d2_side[3:1];
  assign zero8 = d2_side[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {to_byte(neg8[2], d2_quo[2], zero8, 1'b0),
                  to_byte(neg8[1], d2_quo[1], zero8, 1'b1),
                  to_byte(neg8[0], d2_quo[0], zero8, 1'b0),
                  d2_side[HGT_W+3:4]};
    end
  end

endmodule
